@@ src/alln_pkg.sv @@
// Shared widths and constants for the adaptive light level normalizer.
package alln_pkg;

  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 16;

  localparam logic [SAMPLE_W-1:0] LOW_RESET  = 12'd100;
  localparam logic [SAMPLE_W-1:0] HIGH_RESET = 12'd4000;
  localparam logic [SAMPLE_W-1:0] LOW_GATE   = 12'd10;
  localparam logic [SAMPLE_W-1:0] HIGH_GATE  = 12'd4080;

  // span at or below this is treated as too narrow to divide by
  localparam logic signed [SAMPLE_W:0] MIN_SPAN = 13'sd10;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

endpackage

@@ src/alln_if.sv @@
// Valid/ready channel interfaces for samples and normalized results.
interface alln_in_if;
  logic                        valid;
  logic                        ready;
  logic [alln_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface alln_out_if;
  logic                          valid;
  logic                          ready;
  logic [alln_pkg::LEVEL_W-1:0]  level;
  logic                          narrow_span;
  logic [alln_pkg::SAMPLE_W-1:0] low_bound_now;
  logic [alln_pkg::SAMPLE_W-1:0] high_bound_now;

  modport source (output valid, output level, output narrow_span,
                  output low_bound_now, output high_bound_now, input ready);
  modport sink   (input valid, input level, input narrow_span,
                  input low_bound_now, input high_bound_now, output ready);
endinterface

@@ src/adaptive_light_level_normalizer_core.sv @@
// Adaptive light level normalizer: bound tracking and bit-serial divider.
//
// Usage: samples arrive on in_if (valid/ready), one 12-bit reading per beat.
// Each beat updates the running low/high bounds and produces exactly one
// result beat on out_if: the sample mapped into the bound range as a fraction
// with FRAC_BITS fraction bits (saturated to 16 bits), a narrow-span flag, and
// both bounds after the update.
// Timing: the beat is taken in ST_IDLE, the span and class are worked out in
// ST_PREP, then in ST_DIV a restoring radix-2 divider produces one quotient bit
// per cycle, and ST_HOLD moves the result into the output register. Samples at
// or outside a bound, or a narrow span, skip the divider and go from ST_PREP
// straight to ST_HOLD. One item is in work at a time.
// Reset puts the bounds at 100 and 4000 and empties the output register.
// A receiver stall holds the result in the output register; the next sample
// is still taken and worked on, and waits for the register to free up.
module adaptive_light_level_normalizer_core #(
  parameter int FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  alln_in_if.sink     in_if,
  alln_out_if.source  out_if
);
  import alln_pkg::*;

  // result holds at least one bit over the output width to detect saturation
  localparam int EXT_W = (FRAC_BITS + 1 > LEVEL_W + 1) ? FRAC_BITS + 1 : LEVEL_W + 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [EXT_W-1:0] LVL_ONE  = EXT_W'(1) << FRAC_BITS;
  localparam logic [EXT_W-1:0] LVL_HALF = EXT_W'(1) << (FRAC_BITS - 1);
  localparam logic [EXT_W-1:0] LVL_CAP  = EXT_W'(LEVEL_MAX);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t              state_r, state_nxt;
  logic [SAMPLE_W-1:0] low_r, low_nxt;
  logic [SAMPLE_W-1:0] high_r, high_nxt;
  logic [SAMPLE_W-1:0] smp_r, smp_nxt;
  logic [SAMPLE_W-1:0] div_r, div_nxt;
  logic [SAMPLE_W-1:0] rem_r, rem_nxt;
  logic [EXT_W-1:0]    res_r, res_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                narrow_r, narrow_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]  out_level_r, out_level_nxt;
  logic                out_narrow_r, out_narrow_nxt;
  logic [SAMPLE_W-1:0] out_low_r, out_low_nxt;
  logic [SAMPLE_W-1:0] out_high_r, out_high_nxt;

  logic                in_beat;
  logic signed [SAMPLE_W:0] span;
  logic [SAMPLE_W:0]   rem_sh;
  logic                rem_ge;
  logic [LEVEL_W-1:0]  level_sat;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_beat     = in_if.valid && in_if.ready;

  assign span   = $signed({1'b0, high_r}) - $signed({1'b0, low_r});
  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, div_r});
  assign level_sat = (res_r > LVL_CAP) ? LEVEL_MAX : res_r[LEVEL_W-1:0];

  // next-state and datapath
  always_comb begin
    state_nxt      = state_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    smp_nxt        = smp_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    res_nxt        = res_r;
    cnt_nxt        = cnt_r;
    narrow_nxt     = narrow_r;
    out_valid_nxt  = out_valid_r;
    out_level_nxt  = out_level_r;
    out_narrow_nxt = out_narrow_r;
    out_low_nxt    = out_low_r;
    out_high_nxt   = out_high_r;

    // drop the result once the receiver takes it
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        // take the sample and widen the bounds toward it
        if (in_beat) begin
          smp_nxt = in_if.sample;
          if (in_if.sample < low_r && in_if.sample > LOW_GATE) begin
            low_nxt = in_if.sample;
          end
          if (in_if.sample > high_r && in_if.sample < HIGH_GATE) begin
            high_nxt = in_if.sample;
          end
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        // classify the sample, set up the divider if needed
        narrow_nxt = 1'b0;
        priority if (span <= MIN_SPAN) begin
          res_nxt    = LVL_HALF;
          narrow_nxt = 1'b1;
          state_nxt  = ST_HOLD;
        end else if (smp_r <= low_r) begin
          res_nxt   = '0;
          state_nxt = ST_HOLD;
        end else if (smp_r >= high_r) begin
          res_nxt   = LVL_ONE;
          state_nxt = ST_HOLD;
        end else begin
          res_nxt   = '0;
          rem_nxt   = smp_r - low_r;
          div_nxt   = span[SAMPLE_W-1:0];
          cnt_nxt   = CNT_W'(FRAC_BITS);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // one restoring step: one quotient bit per cycle
        rem_nxt = rem_ge ? SAMPLE_W'(rem_sh - {1'b0, div_r}) : rem_sh[SAMPLE_W-1:0];
        res_nxt = {res_r[EXT_W-2:0], rem_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // move the result out once the output register is free
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_level_nxt  = level_sat;
          out_narrow_nxt = narrow_r;
          out_low_nxt    = low_r;
          out_high_nxt   = high_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      low_r       <= LOW_RESET;
      high_r      <= HIGH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      out_valid_r <= out_valid_nxt;
    end
    smp_r        <= smp_nxt;
    div_r        <= div_nxt;
    rem_r        <= rem_nxt;
    res_r        <= res_nxt;
    cnt_r        <= cnt_nxt;
    narrow_r     <= narrow_nxt;
    out_level_r  <= out_level_nxt;
    out_narrow_r <= out_narrow_nxt;
    out_low_r    <= out_low_nxt;
    out_high_r   <= out_high_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.level          = out_level_r;
  assign out_if.narrow_span    = out_narrow_r;
  assign out_if.low_bound_now  = out_low_r;
  assign out_if.high_bound_now = out_high_r;

endmodule

@@ src/alln_checker.sv @@
// Port-level checks for the adaptive light level normalizer, bound to the top.
module alln_checker #(
  parameter int FRAC_BITS = 15
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [alln_pkg::LEVEL_W-1:0]  out_level,
  input logic                          out_narrow_span,
  input logic [alln_pkg::SAMPLE_W-1:0] out_low_bound_now,
  input logic [alln_pkg::SAMPLE_W-1:0] out_high_bound_now
);
  import alln_pkg::*;

  localparam longint unsigned ONE_RAW  = 64'd1 << FRAC_BITS;
  localparam longint unsigned HALF_RAW = 64'd1 << (FRAC_BITS - 1);
  localparam longint unsigned ONE_SAT  = (ONE_RAW > 64'hFFFF) ? 64'hFFFF : ONE_RAW;
  localparam longint unsigned HALF_SAT = (HALF_RAW > 64'hFFFF) ? 64'hFFFF : HALF_RAW;

  // hold a stalled result beat
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_level) && $stable(out_narrow_span))
    else $error("result payload changed while stalled");

  // narrow span reports one half
  a_narrow_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_narrow_span |-> 64'(out_level) == HALF_SAT)
    else $error("narrow span without half level");

  // a wide span keeps the bounds apart and the level within one
  a_wide_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_narrow_span |->
      (13'(out_high_bound_now) > 13'(out_low_bound_now) + 13'd10) &&
      (64'(out_level) <= ONE_SAT))
    else $error("wide span result out of range");

endmodule

bind adaptive_light_level_normalizer_core alln_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_alln_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_level          (out_if.level),
  .out_narrow_span    (out_if.narrow_span),
  .out_low_bound_now  (out_if.low_bound_now),
  .out_high_bound_now (out_if.high_bound_now)
);

@@ verif/testbench.sv @@
// Self-checking testbench for the adaptive light level normalizer core.
`timescale 1ns / 100ps

module testbench;
  import alln_pkg::*;

  localparam int FRAC_BITS   = 15;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = FRAC_BITS + 10;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic                narrow_span;
    logic [SAMPLE_W-1:0] low_bound_now;
    logic [SAMPLE_W-1:0] high_bound_now;
  } norm_result_t;

  logic clk;
  logic rst_n;

  alln_in_if  in_ch ();
  alln_out_if out_ch ();

  adaptive_light_level_normalizer_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // tracked bounds, mirror of the block's state
  logic [SAMPLE_W-1:0] lo_track;
  logic [SAMPLE_W-1:0] hi_track;

  norm_result_t pending_levels[$];
  int           mismatch_count;
  int           quiet_cycles;
  bit           no_idle;

  // Work out the normalized level and the bounds after one sample.
  function automatic norm_result_t predict_normalized(input logic [SAMPLE_W-1:0] s);
    norm_result_t             r;
    logic signed [SAMPLE_W:0] span;
    logic [47:0]              quot;
    if (s < lo_track && s > LOW_GATE) lo_track = s;
    if (s > hi_track && s < HIGH_GATE) hi_track = s;
    span = $signed({1'b0, hi_track}) - $signed({1'b0, lo_track});
    r.narrow_span = 1'b0;
    if (span <= MIN_SPAN) begin
      quot = 48'd1 << (FRAC_BITS - 1);
      r.narrow_span = 1'b1;
    end else if (s <= lo_track) begin
      quot = 48'd0;
    end else if (s >= hi_track) begin
      quot = 48'd1 << FRAC_BITS;
    end else begin
      quot = ({36'd0, s - lo_track} << FRAC_BITS) / {35'd0, span};
    end
    r.level          = (quot > LEVEL_MAX) ? LEVEL_MAX : quot[LEVEL_W-1:0];
    r.low_bound_now  = lo_track;
    r.high_bound_now = hi_track;
    return r;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Send one sample beat; valid stays high when the next beat follows at once.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    pending_levels.push_back(predict_normalized(s));
  endtask

  // Drop valid after the last beat of a burst.
  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic wait_drained();
    stop_sending();
    while (pending_levels.size() != 0) @(negedge clk);
  endtask

  // Pick a sample near a bound, a gate or anywhere in range.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = int'(lo_track) + int'($urandom_range(0, 8)) - 4;
      2, 3: v = int'(hi_track) + int'($urandom_range(0, 8)) - 4;
      4:    v = $urandom_range(0, 14);
      5:    v = $urandom_range(4075, 4095);
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_W-1:0];
  endfunction

  // Bound equality, bound moves, both gates and the field extremes.
  task automatic test_directed_edges();
    logic [SAMPLE_W-1:0] seq[$];
    seq = '{12'd100, 12'd4000, 12'd2050, 12'd50, 12'd4050, 12'd2000, 12'd5,
            12'd10, 12'd4095, 12'd4080, 12'd51, 12'd4049, 12'd11, 12'd4079,
            12'd0, 12'd12, 12'd4078, 12'd2045, 12'd11, 12'd4079, 12'd2730,
            12'd4095, 12'd0};
    foreach (seq[i]) send_sample(seq[i]);
    wait_drained();
  endtask

  // Run with no idle cycles on either side.
  task automatic test_burst_no_idle();
    no_idle = 1'b1;
    repeat (60) send_sample(pick_sample());
    wait_drained();
    no_idle = 1'b0;
  endtask

  // Short bursts, each followed by a full drain.
  task automatic test_drain_pause();
    repeat (4) begin
      repeat (20) send_sample(pick_sample());
      wait_drained();
    end
  endtask

  // Bulk random samples with random idling.
  task automatic test_random_samples();
    repeat (600) send_sample(pick_sample());
    stop_sending();
  endtask

  // Receiver: random stall before each result beat.
  initial begin
    int rx_stall;
    out_ch.ready = 1'b0;
    forever begin
      rx_stall = no_idle ? 0 : $urandom_range(0, 5);
      repeat (rx_stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Compare each result beat against the oldest prediction.
  always @(posedge clk) begin
    norm_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result beat level=%0d flag=%0b lo=%0d hi=%0d", $time,
                 out_ch.level, out_ch.narrow_span, out_ch.low_bound_now,
                 out_ch.high_bound_now);
        mismatch_count++;
      end else begin
        exp_r = pending_levels.pop_front();
        if (out_ch.level !== exp_r.level) begin
          $display("%0t: level expected %0d actual %0d", $time, exp_r.level, out_ch.level);
          mismatch_count++;
        end
        if (out_ch.narrow_span !== exp_r.narrow_span) begin
          $display("%0t: narrow_span expected %0b actual %0b", $time, exp_r.narrow_span,
                   out_ch.narrow_span);
          mismatch_count++;
        end
        if (out_ch.low_bound_now !== exp_r.low_bound_now) begin
          $display("%0t: low_bound_now expected %0d actual %0d", $time, exp_r.low_bound_now,
                   out_ch.low_bound_now);
          mismatch_count++;
        end
        if (out_ch.high_bound_now !== exp_r.high_bound_now) begin
          $display("%0t: high_bound_now expected %0d actual %0d", $time,
                   exp_r.high_bound_now, out_ch.high_bound_now);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.sample   = '0;
    no_idle        = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    lo_track       = LOW_RESET;
    hi_track       = HIGH_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_burst_no_idle();
    test_drain_pause();
    test_random_samples();

    // drain, then give any stray beat time to show up
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_levels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
